>>> rtl/upb_pkg.sv
// ----------------------------------------------------------------------------
// upb_pkg
// Shared types and codes of the micro-op allocate and port binder block.
// ----------------------------------------------------------------------------
`default_nettype none

package upb_pkg;

  // item kinds
  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_DRAIN   = 2'd2;

  // stall codes
  localparam logic [2:0] STALL_NONE  = 3'd0;
  localparam logic [2:0] STALL_ROB   = 3'd1;
  localparam logic [2:0] STALL_LDQ   = 3'd2;
  localparam logic [2:0] STALL_STQ   = 3'd3;
  localparam logic [2:0] STALL_RS    = 3'd4;
  localparam logic [2:0] STALL_DRAIN = 3'd5;

  // configuration register indexes
  localparam logic CFG_CLASS_PORT_MAP = 1'b0;
  localparam logic CFG_DRAIN_HOLD_EN  = 1'b1;

  localparam logic [63:0] CLASS_MAP_RESET = 64'h0101_0101_0101_0101;
  localparam logic [7:0]  LOAD_MAX        = 8'd255;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] class_or_port;
    logic       is_load;
    logic       is_store_addr;
    logic       is_store_data;
    logic       is_nop;
    logic       is_trap;
    logic       rob_has_room;
    logic       ldq_has_room;
    logic       stq_has_room;
    logic       rs_has_room;
    logic       rob_is_empty;
  } upb_item_t;

  typedef struct packed {
    logic       accepted;
    logic [2:0] stall_code;
    logic [2:0] bound_port;
    logic       port_valid;
    logic       insert_ldq;
    logic       insert_stq_addr;
    logic       insert_stq_data;
    logic       insert_rs;
    logic       count_error;
  } upb_result_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } upb_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_last;
  } upb_status_t;

endpackage

`default_nettype wire

>>> rtl/upb_if.sv
// ----------------------------------------------------------------------------
// upb_in_if / upb_out_if
// Valid/ready channels carrying allocate items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface upb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [2:0] class_or_port;
  logic       is_load;
  logic       is_store_addr;
  logic       is_store_data;
  logic       is_nop;
  logic       is_trap;
  logic       rob_has_room;
  logic       ldq_has_room;
  logic       stq_has_room;
  logic       rs_has_room;
  logic       rob_is_empty;

  modport source (
    output valid, kind, class_or_port, is_load, is_store_addr, is_store_data,
           is_nop, is_trap, rob_has_room, ldq_has_room, stq_has_room,
           rs_has_room, rob_is_empty,
    input  ready
  );
  modport sink (
    input  valid, kind, class_or_port, is_load, is_store_addr, is_store_data,
           is_nop, is_trap, rob_has_room, ldq_has_room, stq_has_room,
           rs_has_room, rob_is_empty,
    output ready
  );
endinterface

interface upb_out_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [2:0] stall_code;
  logic [2:0] bound_port;
  logic       port_valid;
  logic       insert_ldq;
  logic       insert_stq_addr;
  logic       insert_stq_data;
  logic       insert_rs;
  logic       count_error;

  modport source (
    output valid, accepted, stall_code, bound_port, port_valid, insert_ldq,
           insert_stq_addr, insert_stq_data, insert_rs, count_error,
    input  ready
  );
  modport sink (
    input  valid, accepted, stall_code, bound_port, port_valid, insert_ldq,
           insert_stq_addr, insert_stq_data, insert_rs, count_error,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/upb_ctrl.sv
// ----------------------------------------------------------------------------
// upb_ctrl
// Sequencer: takes an item, steps the port scan, commits into the result slot.
// ----------------------------------------------------------------------------
`default_nettype none

module upb_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire upb_pkg::upb_status_t status,
  output upb_pkg::upb_cmd_t        cmd
);
  import upb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   slot_free;

  // result slot is free when empty or being taken this cycle
  assign slot_free = !out_valid_r || out_ready;

  // commands to the datapath
  always_comb begin
    in_ready   = (state_r == S_IDLE);
    cmd.load   = (state_r == S_IDLE) && in_valid;
    cmd.scan   = (state_r == S_SCAN) && status.need_scan;
    cmd.commit = (state_r == S_FINISH) && slot_free;
  end

  assign out_valid = out_valid_r;

  // state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (out_valid_r && !out_ready) || cmd.commit;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (!status.need_scan || status.scan_last) state_r <= S_FINISH;
        end
        S_FINISH: begin
          if (slot_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/upb_datapath.sv
// ----------------------------------------------------------------------------
// upb_datapath
// Allocation checks, port load counters, least-loaded scan and result slot.
// ----------------------------------------------------------------------------
`default_nettype none

module upb_datapath #(
  parameter int NUM_PORTS   = 8,
  parameter int NUM_CLASSES = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [63:0]         cfg_wdata,
  input  wire upb_pkg::upb_item_t  item,
  input  wire upb_pkg::upb_cmd_t   cmd,
  output upb_pkg::upb_status_t     status,
  output upb_pkg::upb_result_t     result
);
  import upb_pkg::*;

  localparam int PIW = $clog2(NUM_PORTS);

  logic [63:0]          class_map_r;
  logic                 drain_en_r;
  logic                 drain_pending_r;
  logic [7:0]           port_load_r [NUM_PORTS];

  upb_item_t            item_r;
  logic [2:0]           stall_r;
  logic [NUM_PORTS-1:0] mask_r;
  logic [PIW-1:0]       scan_idx_r;
  logic                 best_valid_r;
  logic [PIW-1:0]       best_port_r;
  logic [7:0]           best_load_r;
  upb_result_t          res_r;

  logic [2:0]           stall_c;
  logic [7:0]           mask_c;
  logic                 drain_hold;
  logic                 need_scan;
  logic                 rel_ok;
  logic                 bind_ok;
  logic [PIW-1:0]       tgt_idx;
  logic [PIW-1:0]       rd_idx;
  logic [7:0]           rd_load;
  logic                 cnt_err;

  // stall priority on the incoming item
  assign drain_hold = drain_en_r && drain_pending_r && !item.rob_is_empty;

  always_comb begin
    priority if (drain_hold)                           stall_c = STALL_DRAIN;
    else if (!item.rob_has_room)                       stall_c = STALL_ROB;
    else if (item.is_load && !item.ldq_has_room)       stall_c = STALL_LDQ;
    else if (item.is_store_addr && !item.stq_has_room) stall_c = STALL_STQ;
    else if (!item.is_nop && !item.rs_has_room)        stall_c = STALL_RS;
    else                                               stall_c = STALL_NONE;
  end

  // allowed ports of the class, empty for an unknown class
  assign mask_c = ({1'b0, item.class_or_port} < 4'(NUM_CLASSES))
                ? class_map_r[{item.class_or_port, 3'b000} +: 8] : 8'h00;

  // status for the sequencer
  assign need_scan = (item_r.kind == KIND_ALLOC) && (stall_r == STALL_NONE)
                   && !item_r.is_nop && !item_r.is_trap;
  assign status.need_scan = need_scan;
  assign status.scan_last = (scan_idx_r == PIW'(NUM_PORTS - 1));

  // single counter read port: scan index, or the port to update at commit
  assign rel_ok  = (item_r.kind == KIND_RELEASE)
                 && ({1'b0, item_r.class_or_port} < 4'(NUM_PORTS));
  assign bind_ok = need_scan && best_valid_r;
  assign tgt_idx = (item_r.kind == KIND_RELEASE) ? item_r.class_or_port[PIW-1:0]
                                                  : best_port_r;
  assign rd_idx  = cmd.commit ? tgt_idx : scan_idx_r;
  assign rd_load = port_load_r[rd_idx];
  assign cnt_err = (rel_ok && (rd_load == 8'd0)) || (bind_ok && (rd_load == LOAD_MAX));

  // configuration, drain flag and load counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_map_r     <= CLASS_MAP_RESET;
      drain_en_r      <= 1'b0;
      drain_pending_r <= 1'b0;
      for (int p = 0; p < NUM_PORTS; p++) port_load_r[p] <= 8'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CLASS_PORT_MAP: class_map_r <= cfg_wdata;
          CFG_DRAIN_HOLD_EN:  drain_en_r  <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        if (item.kind == KIND_DRAIN) begin
          drain_pending_r <= 1'b1;
        end else if (item.kind == KIND_ALLOC && drain_en_r && drain_pending_r
                     && item.rob_is_empty) begin
          drain_pending_r <= 1'b0;
        end
      end
      if (cmd.commit) begin
        if (rel_ok && rd_load != 8'd0) port_load_r[tgt_idx] <= rd_load - 8'd1;
        if (bind_ok && rd_load != LOAD_MAX) port_load_r[tgt_idx] <= rd_load + 8'd1;
      end
    end
  end

  // item capture, least-loaded scan and result slot
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r       <= item;
      stall_r      <= stall_c;
      mask_r       <= mask_c[NUM_PORTS-1:0];
      scan_idx_r   <= '0;
      best_valid_r <= 1'b0;
    end
    if (cmd.scan) begin
      scan_idx_r <= scan_idx_r + PIW'(1);
      // strict compare keeps ties on the lowest port
      if (mask_r[scan_idx_r] && (!best_valid_r || rd_load < best_load_r)) begin
        best_valid_r <= 1'b1;
        best_port_r  <= scan_idx_r;
        best_load_r  <= rd_load;
      end
    end
    if (cmd.commit) begin
      if (item_r.kind == KIND_ALLOC && stall_r == STALL_NONE) begin
        res_r.accepted        <= 1'b1;
        res_r.insert_ldq      <= item_r.is_load;
        res_r.insert_stq_addr <= !item_r.is_load && item_r.is_store_addr;
        res_r.insert_stq_data <= !item_r.is_load && !item_r.is_store_addr
                                 && item_r.is_store_data;
        res_r.insert_rs       <= need_scan;
      end else begin
        res_r.accepted        <= 1'b0;
        res_r.insert_ldq      <= 1'b0;
        res_r.insert_stq_addr <= 1'b0;
        res_r.insert_stq_data <= 1'b0;
        res_r.insert_rs       <= 1'b0;
      end
      res_r.stall_code  <= (item_r.kind == KIND_ALLOC) ? stall_r : STALL_NONE;
      res_r.port_valid  <= bind_ok;
      res_r.bound_port  <= bind_ok ? 3'(best_port_r) : 3'd0;
      res_r.count_error <= cnt_err;
    end
  end

  assign result = res_r;

endmodule

`default_nettype wire

>>> rtl/uop_allocate_port_binder_core.sv
// ----------------------------------------------------------------------------
// uop_allocate_port_binder_core
// Allocation check of micro-ops with least-loaded issue port binding.
// ----------------------------------------------------------------------------
//  channel   direction  handshake      payload
//  in_ch     sink       valid/ready    kind, class, type and room flags
//  out_ch    source     valid/ready    accepted, stall, bound port, inserts
//  cfg_*     write      cfg_we         cfg_index selects, cfg_wdata 64 bits
//
//  An unstalled allocate item that is neither a nop nor a trap is scanned
//  over every port load counter, whether or not its class has a port;
//  every other item skips the scan. A new item is taken after the last
//  commits. The scan reads one port per cycle through one counter read port.
//  Synchronous active-low reset clears counters, drain flags and state,
//  and loads the reset class map; other datapath registers are not reset.
//  A result waits in the output register; a new item is taken meanwhile,
//  and only its commit waits for the output register to free up.
// ----------------------------------------------------------------------------
`default_nettype none

module uop_allocate_port_binder_core #(
  parameter int NUM_PORTS   = 8,
  parameter int NUM_CLASSES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_wdata,
  upb_in_if.sink           in_ch,
  upb_out_if.source        out_ch
);
  import upb_pkg::*;

  upb_item_t   item;
  upb_result_t result;
  upb_cmd_t    cmd;
  upb_status_t status;

  // pack the incoming item
  always_comb begin
    item.kind          = in_ch.kind;
    item.class_or_port = in_ch.class_or_port;
    item.is_load       = in_ch.is_load;
    item.is_store_addr = in_ch.is_store_addr;
    item.is_store_data = in_ch.is_store_data;
    item.is_nop        = in_ch.is_nop;
    item.is_trap       = in_ch.is_trap;
    item.rob_has_room  = in_ch.rob_has_room;
    item.ldq_has_room  = in_ch.ldq_has_room;
    item.stq_has_room  = in_ch.stq_has_room;
    item.rs_has_room   = in_ch.rs_has_room;
    item.rob_is_empty  = in_ch.rob_is_empty;
  end

  upb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  upb_datapath #(
    .NUM_PORTS   (NUM_PORTS),
    .NUM_CLASSES (NUM_CLASSES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .item      (item),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

  // unpack the result
  always_comb begin
    out_ch.accepted        = result.accepted;
    out_ch.stall_code      = result.stall_code;
    out_ch.bound_port      = result.bound_port;
    out_ch.port_valid      = result.port_valid;
    out_ch.insert_ldq      = result.insert_ldq;
    out_ch.insert_stq_addr = result.insert_stq_addr;
    out_ch.insert_stq_data = result.insert_stq_data;
    out_ch.insert_rs       = result.insert_rs;
    out_ch.count_error     = result.count_error;
  end

  // busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input ready right after an accepted item");

  // a bound port implies an accepted micro-op headed for the RS
  a_bind_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.port_valid) |-> (out_ch.accepted && out_ch.insert_rs))
    else $error("port bound without accepted micro-op");

  // a stalled item carries no allocation and no counter error
  a_stall_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.stall_code != STALL_NONE)
      |-> (!out_ch.accepted && !out_ch.port_valid && !out_ch.count_error))
    else $error("stalled item reports allocation");

endmodule

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the micro-op allocate and issue port binder. A
// scoreboard keeps its own copy of the port load counters, drain flag and
// registers, predicts one result item per input item and checks every result
// field by field. Directed items cover stall order, type flags, drain, empty
// classes, underflow and kind 3. Random phases run under several register
// settings and idling patterns, including a counter saturation run with a
// long receiver hold-off.
// ----------------------------------------------------------------------------

module testbench;
  import upb_pkg::*;

  localparam int NUM_PORTS    = 8;
  localparam int NUM_CLASSES  = 8;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 80;
  localparam int SETTLE_CYCLES  = 24;

  // prediction of port binding and stall results
  class alloc_binder_scoreboard;
    logic [63:0] class_map;
    logic        hold_en;
    logic [7:0]  port_load [NUM_PORTS];
    bit          drain_pending;
    upb_result_t expected_q[$];
    int fails;
    int n_items;
    int n_bound;
    int n_unbound;
    int n_count_err;
    int stall_seen [8];

    function new();
      class_map = CLASS_MAP_RESET;
      hold_en = 1'b0;
      foreach (port_load[p]) port_load[p] = '0;
      drain_pending = 1'b0;
      fails = 0;
      n_items = 0;
      n_bound = 0;
      n_unbound = 0;
      n_count_err = 0;
      foreach (stall_seen[s]) stall_seen[s] = 0;
    endfunction

    function void set_config(logic [63:0] map, logic flush);
      class_map = map;
      hold_en = flush;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // work out the result of one accepted item and update the counters
    function void note_item(upb_item_t it);
      upb_result_t r;
      logic [2:0]  stall;
      logic [7:0]  mask;
      int          best;
      int          sel;
      r = '0;
      stall = STALL_NONE;
      sel = it.class_or_port;
      n_items++;
      case (it.kind)
        KIND_RELEASE: begin
          if (sel < NUM_PORTS) begin
            if (port_load[sel] == 8'd0) r.count_error = 1'b1;
            else port_load[sel] = port_load[sel] - 8'd1;
          end
        end
        KIND_DRAIN: begin
          drain_pending = 1'b1;
        end
        KIND_ALLOC: begin
          // drain check comes first, an empty rob ends the drain
          if (hold_en && drain_pending) begin
            if (!it.rob_is_empty) stall = STALL_DRAIN;
            else drain_pending = 1'b0;
          end
          if (stall == STALL_NONE) begin
            if (!it.rob_has_room) stall = STALL_ROB;
            else if (it.is_load && !it.ldq_has_room) stall = STALL_LDQ;
            else if (it.is_store_addr && !it.stq_has_room) stall = STALL_STQ;
            else if (!it.is_nop && !it.rs_has_room) stall = STALL_RS;
          end
          if (stall != STALL_NONE) begin
            r.stall_code = stall;
          end else begin
            r.accepted = 1'b1;
            r.insert_ldq = it.is_load;
            r.insert_stq_addr = !it.is_load && it.is_store_addr;
            r.insert_stq_data = !it.is_load && !it.is_store_addr && it.is_store_data;
            if (!it.is_nop && !it.is_trap) begin
              r.insert_rs = 1'b1;
              mask = (sel < NUM_CLASSES) ? class_map[8*sel +: 8] : 8'd0;
              // least loaded port, ties to the lowest number
              best = -1;
              for (int p = 0; p < NUM_PORTS; p++) begin
                if (mask[p] && (best < 0 || port_load[p] < port_load[best])) best = p;
              end
              if (best >= 0) begin
                r.bound_port = best[2:0];
                r.port_valid = 1'b1;
                if (port_load[best] == LOAD_MAX) r.count_error = 1'b1;
                else port_load[best] = port_load[best] + 8'd1;
                n_bound++;
              end else begin
                n_unbound++;
              end
            end
          end
          stall_seen[stall]++;
        end
        default: ;
      endcase
      if (r.count_error) n_count_err++;
      expected_q.push_back(r);
    endfunction

    function void cmp_field(string name, logic [2:0] want, logic [2:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        fails++;
      end
    endfunction

    // compare one result item against the oldest expectation
    function void check_result(upb_result_t got);
      upb_result_t want;
      if (expected_q.size() == 0) begin
        $error("result item with no expectation pending");
        fails++;
        return;
      end
      want = expected_q.pop_front();
      cmp_field("accepted", want.accepted, got.accepted);
      cmp_field("stall_code", want.stall_code, got.stall_code);
      cmp_field("bound_port", want.bound_port, got.bound_port);
      cmp_field("port_valid", want.port_valid, got.port_valid);
      cmp_field("insert_ldq", want.insert_ldq, got.insert_ldq);
      cmp_field("insert_stq_addr", want.insert_stq_addr, got.insert_stq_addr);
      cmp_field("insert_stq_data", want.insert_stq_data, got.insert_stq_data);
      cmp_field("insert_rs", want.insert_rs, got.insert_rs);
      cmp_field("count_error", want.count_error, got.count_error);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [63:0] cfg_wdata;

  upb_in_if  in_ch();
  upb_out_if out_ch();

  alloc_binder_scoreboard sb;

  int sender_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  int n_cfg;

  uop_allocate_port_binder_core #(
    .NUM_PORTS  (NUM_PORTS),
    .NUM_CLASSES(NUM_CLASSES)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, or a long hold-off on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // handshake monitor: results are checked before the new item is noted
  always @(posedge clk) begin : monitor
    upb_result_t got;
    upb_item_t   seen;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.accepted, out_ch.stall_code, out_ch.bound_port,
               out_ch.port_valid, out_ch.insert_ldq, out_ch.insert_stq_addr,
               out_ch.insert_stq_data, out_ch.insert_rs, out_ch.count_error};
        sb.check_result(got);
      end
      if (in_ch.valid && in_ch.ready) begin
        seen = {in_ch.kind, in_ch.class_or_port, in_ch.is_load,
                in_ch.is_store_addr, in_ch.is_store_data, in_ch.is_nop,
                in_ch.is_trap, in_ch.rob_has_room, in_ch.ldq_has_room,
                in_ch.stq_has_room, in_ch.rs_has_room, in_ch.rob_is_empty};
        sb.note_item(seen);
      end
    end
  end

  // watchdog on cycles with no item moving on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("testbench NOT OK");
    $finish;
  end

  function automatic logic chance(int pct);
    return $urandom_range(99) < pct;
  endfunction

  // types: load, store addr, store data, nop, trap
  // rooms: rob room, ldq room, stq room, rs room, rob empty
  function automatic upb_item_t mk_item(logic [1:0] kind, logic [2:0] sel,
                                        logic [4:0] types, logic [4:0] rooms);
    return {kind, sel, types, rooms};
  endfunction

  function automatic upb_item_t rand_item();
    logic [1:0] kind;
    int r;
    r = $urandom_range(99);
    if (r < 72) kind = KIND_ALLOC;
    else if (r < 90) kind = KIND_RELEASE;
    else if (r < 98) kind = KIND_DRAIN;
    else kind = KIND_UNUSED;
    return mk_item(kind, 3'($urandom_range(7)),
                   {chance(25), chance(20), chance(20), chance(8), chance(8)},
                   {chance(90), chance(90), chance(90), chance(90), chance(50)});
  endfunction

  // offer one item, entered and left at a falling edge
  task automatic send_item(upb_item_t it);
    int gaps;
    gaps = 0;
    while ($urandom_range(99) < sender_idle_pct) gaps++;
    if (gaps > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gaps) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.kind          <= it.kind;
    in_ch.class_or_port <= it.class_or_port;
    in_ch.is_load       <= it.is_load;
    in_ch.is_store_addr <= it.is_store_addr;
    in_ch.is_store_data <= it.is_store_data;
    in_ch.is_nop        <= it.is_nop;
    in_ch.is_trap       <= it.is_trap;
    in_ch.rob_has_room  <= it.rob_has_room;
    in_ch.ldq_has_room  <= it.ldq_has_room;
    in_ch.stq_has_room  <= it.stq_has_room;
    in_ch.rs_has_room   <= it.rs_has_room;
    in_ch.rob_is_empty  <= it.rob_is_empty;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // drop valid and wait for every expected result
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // write both registers, only while idle
  task automatic set_config(logic [63:0] map, logic flush);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CLASS_PORT_MAP;
    cfg_wdata <= map;
    @(negedge clk);
    cfg_index <= CFG_DRAIN_HOLD_EN;
    cfg_wdata <= {63'd0, flush};
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_config(map, flush);
    n_cfg += 2;
  endtask

  task automatic run_random(int n, int idle_pct, int stall_pct);
    sender_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      // halfway through, the sender waits for all results
      if (i == n / 2) drain_results();
      send_item(rand_item());
    end
    drain_results();
  endtask

  initial begin : main
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_CLASS_PORT_MAP;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_ALLOC;
    in_ch.class_or_port = '0;
    in_ch.is_load = 1'b0;
    in_ch.is_store_addr = 1'b0;
    in_ch.is_store_data = 1'b0;
    in_ch.is_nop = 1'b0;
    in_ch.is_trap = 1'b0;
    in_ch.rob_has_room = 1'b0;
    in_ch.ldq_has_room = 1'b0;
    in_ch.stq_has_room = 1'b0;
    in_ch.rs_has_room = 1'b0;
    in_ch.rob_is_empty = 1'b0;
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b0;
    n_cfg = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: underflow, stall order, type flags, classes, drain ignored
    send_item(mk_item(KIND_RELEASE, 3'd0, 5'b00000, 5'b11111));
    send_item(mk_item(KIND_RELEASE, 3'd7, 5'b00000, 5'b11111));
    send_item(mk_item(KIND_ALLOC,   3'd0, 5'b00000, 5'b11111));
    send_item(mk_item(KIND_RELEASE, 3'd0, 5'b00000, 5'b00000));
    send_item(mk_item(KIND_ALLOC,   3'd1, 5'b11000, 5'b00001));
    send_item(mk_item(KIND_ALLOC,   3'd2, 5'b11000, 5'b10001));
    send_item(mk_item(KIND_ALLOC,   3'd3, 5'b01000, 5'b11001));
    send_item(mk_item(KIND_ALLOC,   3'd4, 5'b00000, 5'b11100));
    send_item(mk_item(KIND_ALLOC,   3'd5, 5'b00010, 5'b11100));
    send_item(mk_item(KIND_ALLOC,   3'd6, 5'b00001, 5'b11111));
    send_item(mk_item(KIND_ALLOC,   3'd2, 5'b11100, 5'b11111));
    send_item(mk_item(KIND_ALLOC,   3'd3, 5'b01100, 5'b11111));
    send_item(mk_item(KIND_ALLOC,   3'd4, 5'b00100, 5'b11111));
    send_item(mk_item(KIND_ALLOC,   3'd7, 5'b00000, 5'b11111));
    send_item(mk_item(KIND_DRAIN,   3'd0, 5'b00000, 5'b00000));
    send_item(mk_item(KIND_ALLOC,   3'd1, 5'b00000, 5'b11110));
    send_item(mk_item(KIND_UNUSED,  3'd7, 5'b11111, 5'b11111));
    drain_results();

    // directed: all ports allowed, drain holds allocation
    set_config(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_item(mk_item(KIND_ALLOC,   3'd3, 5'b00000, 5'b11111));
    send_item(mk_item(KIND_DRAIN,   3'd0, 5'b00000, 5'b11111));
    send_item(mk_item(KIND_ALLOC,   3'd3, 5'b00000, 5'b11110));
    send_item(mk_item(KIND_ALLOC,   3'd3, 5'b00000, 5'b01111));
    send_item(mk_item(KIND_ALLOC,   3'd3, 5'b00000, 5'b11110));
    drain_results();

    // directed: empty classes bind no port
    set_config(64'h0, 1'b0);
    send_item(mk_item(KIND_ALLOC,   3'd5, 5'b00000, 5'b11111));
    send_item(mk_item(KIND_RELEASE, 3'd1, 5'b00000, 5'b00000));
    drain_results();

    // random under several settings and idling patterns
    set_config(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    run_random(220, 0, 0);
    set_config({$urandom, $urandom}, 1'b1);
    run_random(220, 47, 0);

    // saturation of port 0 while the receiver holds off
    set_config(CLASS_MAP_RESET, 1'b0);
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b1;
    for (int i = 0; i < 270; i++) begin
      send_item(mk_item(KIND_ALLOC, 3'($urandom_range(7)), 5'b00000, 5'b11111));
    end
    for (int i = 0; i < 10; i++) begin
      send_item(mk_item(KIND_RELEASE, 3'd0, 5'b00000, 5'b00000));
    end
    drain_results();

    set_config(64'h8040_2010_0804_0201, 1'b0);
    run_random(200, 0, 47);
    set_config(64'h0, 1'b1);
    run_random(100, 22, 22);
    set_config({$urandom, $urandom}, 1'b0);
    run_random(100, 22, 22);

    // let any stray result show up
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d items, %0d bound, %0d accepted without a port, %0d count errors",
             sb.n_items, sb.n_bound, sb.n_unbound, sb.n_count_err);
    $display("stalls rob %0d ldq %0d stq %0d rs %0d drain %0d, %0d register writes",
             sb.stall_seen[STALL_ROB], sb.stall_seen[STALL_LDQ], sb.stall_seen[STALL_STQ],
             sb.stall_seen[STALL_RS], sb.stall_seen[STALL_DRAIN], n_cfg);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
